### design/tccw_pkg.sv
// Package for the text console cell writer.
// Holds constants, register indexes and the control structs shared by the modules.
// No dependencies.
package tccw_pkg;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Field widths of the transfers
	localparam int CHAR_W  = 8;
	localparam int NUM_W   = 32;
	localparam int ADDR_W  = 11;
	localparam int WORD_W  = 16;
	localparam int ROWO_W  = 5;
	localparam int COLO_W  = 7;
	localparam int COLOR_W = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COLOR_W;
	localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'b1;

	// Request kinds
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_NUM  = 1'b1;

	// Character codes
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'h30;

	// Decimal conversion: floor(n/10) = (n * RECIP_10) >> RECIP_SHIFT for any 32-bit n
	localparam int MAX_DIGITS  = 10;
	localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
	localparam logic [NUM_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;
	localparam int QUOT_W      = 2*NUM_W - RECIP_SHIFT;

	// Sequencer to digit unit
	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic pop;
	} dig_ctrl_t;

	// Digit unit to sequencer
	typedef struct packed {
		logic       conv_done;
		logic       final_digit;
		logic [3:0] digit;
	} dig_stat_t;

	// Sequencer to cursor
	typedef struct packed {
		logic step;
		logic newline;
	} cur_ctrl_t;

	// Cursor to sequencer: address of the current cell and cursor after the operation
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ROWO_W-1:0] row_nx;
		logic [COLO_W-1:0] col_nx;
	} cur_stat_t;

endpackage

### design/tccw_req_if.sv
// Request channel of the text console cell writer.
// Depends on tccw_pkg for field widths.
interface tccw_req_if import tccw_pkg::*; ;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CHAR_W-1:0] char_code;
	logic [NUM_W-1:0]  number;

	modport source (output valid, req_type, char_code, number, input ready);
	modport sink   (input valid, req_type, char_code, number, output ready);
endinterface

### design/tccw_res_if.sv
// Result channel of the text console cell writer.
// Depends on tccw_pkg for field widths.
interface tccw_res_if import tccw_pkg::*; ;
	logic              valid;
	logic              ready;
	logic              write_enable;
	logic [ADDR_W-1:0] cell_address;
	logic [WORD_W-1:0] cell_word;
	logic [ROWO_W-1:0] cursor_row_now;
	logic [COLO_W-1:0] cursor_col_now;
	logic              last;

	modport source (output valid, write_enable, cell_address, cell_word, cursor_row_now,
		cursor_col_now, last, input ready);
	modport sink   (input valid, write_enable, cell_address, cell_word, cursor_row_now,
		cursor_col_now, last, output ready);
endinterface

### design/tccw_digit_unit.sv
// Decimal digit unit: shared reciprocal multiplier, remainder and digit store.
// Each digit takes a multiply step and a divide step; digits are read back most significant first.
// Depends on tccw_pkg.
module tccw_digit_unit import tccw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dig_ctrl_t        ctrl,
	input  logic [NUM_W-1:0] number,
	output dig_stat_t        stat
);

	localparam logic [DIG_IDX_W-1:0] IDX_LAST = DIG_IDX_W'(MAX_DIGITS - 1);

	logic [NUM_W-1:0]     n_q;
	logic [2*NUM_W-1:0]   prod_q;
	logic [3:0]           store_q [MAX_DIGITS];
	logic [DIG_IDX_W-1:0] ptr_q;

	logic [QUOT_W-1:0] quot;
	logic [NUM_W-1:0]  quot_x10;
	logic [NUM_W-1:0]  rem;

	// Quotient from the registered product, remainder by shift and add
	assign quot     = prod_q[2*NUM_W-1:RECIP_SHIFT];
	assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem      = n_q - quot_x10;

	assign stat.conv_done   = (quot == '0) || (ptr_q == IDX_LAST);
	assign stat.final_digit = (ptr_q == '0);
	assign stat.digit       = store_q[ptr_q];

	// Hold the value under conversion, the product and the stored digits
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			n_q <= number;
		end else if (ctrl.div) begin
			n_q <= NUM_W'(quot);
		end
		if (ctrl.mul) begin
			prod_q <= (2*NUM_W)'(n_q) * (2*NUM_W)'(RECIP_10);
		end
		if (ctrl.div) begin
			store_q[ptr_q] <= rem[3:0];
		end
	end

	// Advance the pointer while storing, step it back while reading out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctrl.load) begin
			ptr_q <= '0;
		end else if (ctrl.div && !stat.conv_done) begin
			ptr_q <= ptr_q + 1'b1;
		end else if (ctrl.pop) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

endmodule

### design/tccw_cursor.sv
// Cursor of the console: row and column with wrap, and the cell address.
// Depends on tccw_pkg.
module tccw_cursor import tccw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cur_ctrl_t ctrl,
	output cur_stat_t stat
);

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int FULL_W = COL_W + ROW_W;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_down;
	logic [ROW_W-1:0] row_nx;
	logic [COL_W-1:0] col_nx;
	logic [FULL_W-1:0] addr_full;
	logic [FULL_W+ADDR_W-1:0] addr_ext;
	logic [ROW_W+ROWO_W-1:0]  row_ext;
	logic [COL_W+COLO_W-1:0]  col_ext;

	// Next row down, wrapping to the top
	assign row_down = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;

	// Cursor after a newline or after a cell write
	always_comb begin
		if (ctrl.newline) begin
			col_nx = '0;
			row_nx = row_down;
		end else if (col_q == COL_LAST) begin
			col_nx = '0;
			row_nx = row_down;
		end else begin
			col_nx = col_q + 1'b1;
			row_nx = row_q;
		end
	end

	assign addr_full = FULL_W'(row_q) * FULL_W'(COLUMNS) + FULL_W'(col_q);

	// Fit to the port widths, dropping high bits where the geometry exceeds them
	assign addr_ext    = {{ADDR_W{1'b0}}, addr_full};
	assign row_ext     = {{ROWO_W{1'b0}}, row_nx};
	assign col_ext     = {{COLO_W{1'b0}}, col_nx};
	assign stat.addr   = addr_ext[ADDR_W-1:0];
	assign stat.row_nx = row_ext[ROWO_W-1:0];
	assign stat.col_nx = col_ext[COLO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (ctrl.step || ctrl.newline) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

endmodule

### design/text_console_cell_writer.sv
// Top level of the text console cell writer: sequencer, colour registers, result register.
// Depends on tccw_pkg, tccw_req_if, tccw_res_if, tccw_digit_unit and tccw_cursor.
//
//   channel   kind            carries
//   request   valid/ready in  req_type, char_code, number
//   result    valid/ready out write_enable, cell_address, cell_word, cursor, last
//   wr_*      write only      colour registers (index 0 foreground, 1 background)
//
// A character or newline goes from the idle state to the emit state, which registers its result.
// A number of d digits runs a multiply state and a divide state per digit on the shared
// reciprocal multiplier, then emits one result a cycle while the result channel is not stalled.
// request.ready is high only while idle. A stalled result holds the sequencer.
// Reset clears the cursor, the colours and the sequencer; no clearing pass.
module text_console_cell_writer import tccw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tccw_req_if.sink              request,
	tccw_res_if.source            result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]         state_q;
	logic [COLOR_W-1:0] fore_q;
	logic [COLOR_W-1:0] back_q;
	logic               kind_q;
	logic [CHAR_W-1:0]  char_q;

	logic res_valid_q;
	logic res_we_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [WORD_W-1:0] res_word_q;
	logic [ROWO_W-1:0] res_row_q;
	logic [COLO_W-1:0] res_col_q;
	logic              res_last_q;

	dig_ctrl_t dig_ctrl;
	dig_stat_t dig_stat;
	cur_ctrl_t cur_ctrl;
	cur_stat_t cur_stat;

	logic              accept;
	logic              slot_free;
	logic              fire;
	logic              is_nl;
	logic              is_last;
	logic [CHAR_W-1:0] code;

	tccw_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dig_ctrl),
		.number (request.number),
		.stat   (dig_stat)
	);

	tccw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cur_ctrl),
		.stat   (cur_stat)
	);

	assign request.ready = (state_q == ST_IDLE);
	assign accept        = request.valid && request.ready;
	assign slot_free     = !res_valid_q || result.ready;
	assign fire          = (state_q == ST_EMIT) && slot_free;
	assign is_nl         = (kind_q == REQ_CHAR) && (char_q == NEWLINE_CODE);
	assign is_last       = (kind_q == REQ_CHAR) || dig_stat.final_digit;
	assign code          = (kind_q == REQ_NUM) ? DIGIT_BASE + {4'b0000, dig_stat.digit} : char_q;

	// Drive the digit unit and the cursor
	always_comb begin
		dig_ctrl.load    = accept && (request.req_type == REQ_NUM);
		dig_ctrl.mul     = (state_q == ST_MUL);
		dig_ctrl.div     = (state_q == ST_DIV);
		dig_ctrl.pop     = fire && (kind_q == REQ_NUM) && !dig_stat.final_digit;
		cur_ctrl.step    = fire && !is_nl;
		cur_ctrl.newline = fire && is_nl;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (request.req_type == REQ_NUM) ? ST_MUL : ST_EMIT;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= dig_stat.conv_done ? ST_EMIT : ST_MUL;
				end
				ST_EMIT: begin
					if (fire && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= request.req_type;
			char_q <= request.char_code;
		end
	end

	// Colour registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= '0;
			back_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_FORE: fore_q <= wr_data;
				REG_BACK: back_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Result valid: set on a new result, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_we_q   <= !is_nl;
			res_addr_q <= is_nl ? '0 : cur_stat.addr;
			res_word_q <= is_nl ? '0 : {back_q, fore_q, code};
			res_row_q  <= cur_stat.row_nx;
			res_col_q  <= cur_stat.col_nx;
			res_last_q <= is_last;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.write_enable   = res_we_q;
	assign result.cell_address   = res_addr_q;
	assign result.cell_word      = res_word_q;
	assign result.cursor_row_now = res_row_q;
	assign result.cursor_col_now = res_col_q;
	assign result.last           = res_last_q;

endmodule

### tb/sv/tb_text_console_cell_writer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console cell writer: directed rows, then random phases.
// Depends on tccw_pkg, tccw_req_if, tccw_res_if and the text_console_cell_writer RTL.
module tb_text_console_cell_writer import tccw_pkg::*; ;

	localparam int SCREEN_COLS    = COLUMNS_DEF;
	localparam int SCREEN_ROWS    = ROWS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] code;
		logic [NUM_W-1:0]  value;
	} console_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
		logic [ROWO_W-1:0] row;
		logic [COLO_W-1:0] col;
		logic              last;
	} cell_write_t;

	typedef struct packed {
		logic         typed;
		console_req_t req;
		cell_write_t  want;
	} directed_row_t;

	typedef enum {MIXED, FILL_LINES, SEEK_BOTTOM} run_shape_t;

	localparam cell_write_t NO_CELL = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	tccw_req_if req_ch ();
	tccw_res_if res_ch ();

	text_console_cell_writer #(
		.COLUMNS(SCREEN_COLS),
		.ROWS(SCREEN_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(res_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Predictor state: cursor and colours as the block should hold them
	int                   pred_row;
	int                   pred_col;
	logic [COLOR_W-1:0]   fg_color;
	logic [COLOR_W-1:0]   bg_color;
	cell_write_t          writes_due[$];
	directed_row_t        directed_rows[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Write one cell at the cursor and advance it, wrapping column and row
	function automatic cell_write_t write_cell(logic [CHAR_W-1:0] code, logic is_last);
		cell_write_t c;
		c.we = 1'b1;
		c.addr = ADDR_W'(pred_row * SCREEN_COLS + pred_col);
		c.word = {bg_color, fg_color, code};
		pred_col++;
		if (pred_col >= SCREEN_COLS) begin
			pred_col = 0;
			pred_row++;
			if (pred_row >= SCREEN_ROWS)
				pred_row = 0;
		end
		c.row = ROWO_W'(pred_row);
		c.col = COLO_W'(pred_col);
		c.last = is_last;
		return c;
	endfunction

	// Queue the cell writes that one accepted request causes
	function automatic void predict_writes(console_req_t r);
		int               digits[MAX_DIGITS];
		int               count;
		int               k;
		logic [NUM_W-1:0] rest;
		cell_write_t      nl;
		if (r.kind == REQ_CHAR) begin
			if (r.code == NEWLINE_CODE) begin
				pred_col = 0;
				pred_row = (pred_row == SCREEN_ROWS - 1) ? 0 : pred_row + 1;
				nl = NO_CELL;
				nl.row = ROWO_W'(pred_row);
				nl.col = '0;
				nl.last = 1'b1;
				writes_due.push_back(nl);
			end else begin
				writes_due.push_back(write_cell(r.code, 1'b1));
			end
		end else begin
			rest = r.value;
			count = 0;
			do begin
				digits[count] = rest % 10;
				rest = rest / 10;
				count++;
			end while (rest != 0 && count < MAX_DIGITS);
			// most significant digit first
			for (k = count - 1; k >= 0; k--)
				writes_due.push_back(write_cell(CHAR_W'(DIGIT_BASE + digits[k]), k == 0));
		end
	endfunction

	// Draw a request; the shape steers the cursor towards line and screen wraps
	function automatic console_req_t random_req(run_shape_t shape);
		console_req_t r;
		int           pick;
		int           nl_pct;
		int           num_pct;
		int           digits;
		longint       floor_v;
		longint       ceil_v;
		longint       draw;
		pick = $urandom_range(0, 99);
		// ignored fields carry noise
		r.kind = REQ_CHAR;
		r.code = CHAR_W'($urandom);
		r.value = $urandom;
		case (shape)
			MIXED: begin
				nl_pct = 20;
				num_pct = 45;
			end
			FILL_LINES: begin
				nl_pct = 0;
				num_pct = 80;
			end
			default: begin
				nl_pct = (pred_row != SCREEN_ROWS - 1) ? 85 : 0;
				num_pct = 90;
			end
		endcase
		if (pick < nl_pct) begin
			r.code = NEWLINE_CODE;
		end else if (pick < nl_pct + num_pct) begin
			r.kind = REQ_NUM;
			digits = (shape == MIXED) ? $urandom_range(1, MAX_DIGITS) : MAX_DIGITS;
			if (shape != MIXED || $urandom_range(0, 4) != 0) begin
				floor_v = 1;
				repeat (digits - 1) floor_v = floor_v * 10;
				ceil_v = (digits == MAX_DIGITS) ? 64'hFFFF_FFFF : floor_v * 10 - 1;
				if (digits == 1)
					floor_v = 0;
				draw = $urandom;
				r.value = NUM_W'(floor_v + draw % (ceil_v - floor_v + 1));
			end
		end
		return r;
	endfunction

	task automatic report_cell(string what, cell_write_t want, cell_write_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s: want we=%0b addr=%0d word=%h row=%0d col=%0d last=%0b", what,
				want.we, want.addr, want.word, want.row, want.col, want.last,
				"\n    got  we=%0b addr=%0d word=%h row=%0d col=%0d last=%0b",
				got.we, got.addr, got.word, got.row, got.col, got.last);
	endtask

	// Offer one request, with an optional gap first; returns at the transfer edge
	task automatic send_request(console_req_t r);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.char_code <= r.code;
		req_ch.number <= r.value;
		do @(posedge clk); while (!req_ch.ready);
		predict_writes(r);
	endtask

	// Drop valid and hold until every due write has come back
	task automatic drain(int settle);
		req_ch.valid <= 1'b0;
		while (writes_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_colour(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (idx == REG_FORE)
			fg_color = val;
		else
			bg_color = val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic run_phase(run_shape_t shape, int count, logic [COLOR_W-1:0] fg,
		logic [COLOR_W-1:0] bg, bit idle);
		drain(4);
		write_colour(REG_FORE, fg);
		write_colour(REG_BACK, bg);
		idle_on = idle;
		repeat (count) send_request(random_req(shape));
	endtask

	// Stall the result channel in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Check each result transfer against the oldest due write
	always @(posedge clk) begin : check_results
		cell_write_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.write_enable, res_ch.cell_address, res_ch.cell_word,
				res_ch.cursor_row_now, res_ch.cursor_col_now, res_ch.last};
			if (writes_due.size() == 0)
				report_cell("result with nothing due", NO_CELL, got);
			else if (got !== writes_due[0])
				report_cell("result mismatch", writes_due.pop_front(), got);
			else
				void'(writes_due.pop_front());
		end
	end

	// Count cycles without any transfer; give up when the block stalls
	always @(posedge clk) begin
		if (!arst_n || wr_en || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_text_console_cell_writer: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_CHAR;
		req_ch.char_code <= '0;
		req_ch.number <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_FORE;
		wr_data <= '0;
		pred_row = 0;
		pred_col = 0;
		fg_color = '0;
		bg_color = '0;

		// Typed rows start from the reset cursor with both colours at zero
		directed_rows.push_back({1'b1, REQ_CHAR, 8'h00, 32'h0000_0000,
			1'b1, 11'd0, 16'h0000, 5'd0, 7'd1, 1'b1});
		directed_rows.push_back({1'b1, REQ_CHAR, 8'hFF, 32'hFFFF_FFFF,
			1'b1, 11'd1, 16'h00FF, 5'd0, 7'd2, 1'b1});
		directed_rows.push_back({1'b1, REQ_CHAR, NEWLINE_CODE, 32'h0000_0000,
			1'b0, 11'd0, 16'h0000, 5'd1, 7'd0, 1'b1});
		// zero prints a single digit; the newline code is ignored on a number
		directed_rows.push_back({1'b1, REQ_NUM, NEWLINE_CODE, 32'h0000_0000,
			1'b1, 11'd80, 16'h0030, 5'd1, 7'd1, 1'b1});
		directed_rows.push_back({1'b0, REQ_NUM, 8'h00, 32'hFFFF_FFFF, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'hFF, 32'd1000000000, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'h00, 32'd999999999, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'h00, 32'd9, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'h00, 32'd10, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'h55, 32'h5555_5555, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'hAA, 32'hAAAA_AAAA, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, 8'h55, 32'hAAAA_AAAA, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, 8'hAA, 32'h5555_5555, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, 8'h09, 32'h0000_0000, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, 8'h0B, 32'h0000_000A, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, NEWLINE_CODE, 32'hFFFF_FFFF, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, NEWLINE_CODE, 32'h0000_0000, NO_CELL});
		directed_rows.push_back({1'b0, REQ_NUM, 8'hFF, 32'd42, NO_CELL});
		directed_rows.push_back({1'b0, REQ_CHAR, DIGIT_BASE, 32'h0000_0000, NO_CELL});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows; a typed expectation stands in place of the predicted one
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].req);
			if (directed_rows[i].typed) begin
				void'(writes_due.pop_back());
				writes_due.push_back(directed_rows[i].want);
			end
		end

		// Random phases, each under its own colour setting
		run_phase(MIXED, 25, 4'hF, 4'h0, 1'b1);
		run_phase(FILL_LINES, 20, 4'h0, 4'hF, 1'b1);
		run_phase(SEEK_BOTTOM, 40, COLOR_W'($urandom_range(1, 14)),
			COLOR_W'($urandom_range(1, 14)), 1'b1);
		run_phase(MIXED, 20, 4'hF, 4'hF, 1'b0);

		drain(40);
		if (writes_due.size() != 0) begin
			mismatches += writes_due.size();
			$display("%0d cell writes never arrived", writes_due.size());
		end
		if (mismatches == 0)
			$display("tb_text_console_cell_writer: done, clean");
		else
			$display("tb_text_console_cell_writer: done, errors");
		$finish;
	end

endmodule
